>>> hdl/circular_window_gather_macros.svh
// Assertion macros shared by the circular window gather modules.
`ifndef CIRCULAR_WINDOW_GATHER_MACROS_SVH
`define CIRCULAR_WINDOW_GATHER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define CWG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low
`define CWG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CWG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CWG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hdl/cwg_pkg.sv
// Types, widths and constants for the circular window gather block.
`timescale 1ns / 1ps

package cwg_pkg;

    // Default sizes of the image store and window
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_RADIUS   = 7;

    // Field widths
    localparam int CH_W      = 3;
    localparam int DIM_W     = 7;
    localparam int RAD_W     = 3;
    localparam int CHAN_W    = 2;
    localparam int POS_W     = 6;
    localparam int SHIFT_W   = 4;
    localparam int SAMPLE_W  = 32;
    localparam int DEPTH_W   = 10;
    localparam int SLOT_W    = 8;
    localparam int WRAP_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    // Stream packing
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int IN_CHAN_LO  = 0;
    localparam int IN_ROW_LO   = 2;
    localparam int IN_COL_LO   = 8;
    localparam int IN_SY_LO    = 14;
    localparam int IN_SX_LO    = 18;
    localparam int IN_SMP_LO   = 22;
    localparam int OUT_CHAN_LO = 32;
    localparam int OUT_DEP_LO  = 34;
    localparam int OUT_PAD_LO  = 44;

    // Register reset values
    localparam logic [CH_W-1:0]  RST_CHANNELS = 3'd1;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 7'd64;
    localparam logic [DIM_W-1:0] RST_WIDTH    = 7'd64;
    localparam logic [RAD_W-1:0] RST_RADIUS   = 3'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    // Input request kinds
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_GATHER = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WRAP,
        S_EMIT,
        S_ERR
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch request fields
        logic mem_wr;    // store loaded sample
        logic wrap;      // one wrap step, depth base update
        logic rd_start;  // read channel 0
        logic emit;      // present sample, read next channel
        logic emit_err;  // present error result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic gather;    // incoming request is a gather
        logic in_ok;     // incoming request passes range checks
        logic wrap_done; // wrapped row and column both inside image
        logic out_free;  // output register can take a result
        logic last;      // current channel is the final one
    } t_status;

endpackage

>>> hdl/cwg_ctrl.sv
// Controller state machine for the circular window gather block.
`timescale 1ns / 1ps
`include "circular_window_gather_macros.svh"

module cwg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cwg_pkg::t_status i_status,
    output cwg_pkg::t_cmd   o_cmd
);

    cwg_pkg::t_state r_state;
    cwg_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cwg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            cwg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_status.in_ok) begin
                        n_state = cwg_pkg::S_ERR;
                    end else if (i_status.gather) begin
                        n_state = cwg_pkg::S_WRAP;
                    end else begin
                        o_cmd.mem_wr = 1'b1;
                    end
                end
            end
            cwg_pkg::S_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (i_status.wrap_done) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = cwg_pkg::S_EMIT;
                end
            end
            cwg_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = cwg_pkg::S_IDLE;
                    end
                end
            end
            cwg_pkg::S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = cwg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwg_pkg::S_IDLE;
            end
        endcase
    end

    `CWG_ASSERT_IMP(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit || o_cmd.emit_err, i_status.out_free, "result issued while output register full")
    `CWG_ASSERT_NXT(a_gather_to_wrap, i_clk, i_rst_n, r_state == cwg_pkg::S_IDLE && i_in_valid && i_status.in_ok && i_status.gather, r_state == cwg_pkg::S_WRAP, "valid gather did not start wrap")
    `CWG_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, o_cmd.emit && i_status.last, r_state == cwg_pkg::S_IDLE, "final channel did not end gather")

endmodule

>>> hdl/cwg_dp.sv
// Datapath for the circular window gather block: config, checks, wrap, image store, output.
`timescale 1ns / 1ps
`include "circular_window_gather_macros.svh"

module cwg_dp #(
    parameter int MAX_CHANNELS = cwg_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = cwg_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = cwg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS   = cwg_pkg::DEF_MAX_RADIUS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cwg_pkg::t_cmd                       i_cmd,
    output cwg_pkg::t_status                    o_status,
    input  logic                                i_cfg_we,
    input  logic [cwg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cwg_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                                i_op,
    input  logic [cwg_pkg::CHAN_W-1:0]          i_chan,
    input  logic [cwg_pkg::POS_W-1:0]           i_row,
    input  logic [cwg_pkg::POS_W-1:0]           i_col,
    input  logic signed [cwg_pkg::SHIFT_W-1:0]  i_shift_y,
    input  logic signed [cwg_pkg::SHIFT_W-1:0]  i_shift_x,
    input  logic [cwg_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic                                i_m_ready,
    output logic                                o_m_valid,
    output logic [cwg_pkg::SAMPLE_W-1:0]        o_data,
    output logic [cwg_pkg::CHAN_W-1:0]          o_out_chan,
    output logic [cwg_pkg::DEPTH_W-1:0]         o_depth_index,
    output logic                                o_last,
    output logic                                o_error
);

    localparam int DEPTH  = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [cwg_pkg::CH_W-1:0]  r_channels;
    logic [cwg_pkg::DIM_W-1:0] r_height;
    logic [cwg_pkg::DIM_W-1:0] r_width;
    logic [cwg_pkg::RAD_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= cwg_pkg::RST_CHANNELS;
            r_height   <= cwg_pkg::RST_HEIGHT;
            r_width    <= cwg_pkg::RST_WIDTH;
            r_radius   <= cwg_pkg::RST_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cwg_pkg::CFG_CHANNELS: r_channels <= i_cfg_data[cwg_pkg::CH_W-1:0];
                cwg_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data;
                cwg_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                cwg_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[cwg_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate registers to the built sizes
    logic [cwg_pkg::CH_W-1:0]  w_ch;
    logic [cwg_pkg::DIM_W-1:0] w_h;
    logic [cwg_pkg::DIM_W-1:0] w_w;
    logic [cwg_pkg::RAD_W-1:0] w_r;

    assign w_ch = (int'(r_channels) > MAX_CHANNELS) ? cwg_pkg::CH_W'(MAX_CHANNELS) : r_channels;
    assign w_h  = (int'(r_height) > MAX_HEIGHT) ? cwg_pkg::DIM_W'(MAX_HEIGHT) : r_height;
    assign w_w  = (int'(r_width) > MAX_WIDTH) ? cwg_pkg::DIM_W'(MAX_WIDTH) : r_width;
    assign w_r  = (int'(r_radius) > MAX_RADIUS) ? cwg_pkg::RAD_W'(MAX_RADIUS) : r_radius;

    // Range checks on the incoming request
    logic signed [4:0] w_dy5;
    logic signed [4:0] w_dx5;
    logic signed [4:0] w_r5;
    logic              w_pos_ok;
    logic              w_chan_ok;
    logic              w_shift_ok;

    assign w_dy5      = {i_shift_y[cwg_pkg::SHIFT_W-1], i_shift_y};
    assign w_dx5      = {i_shift_x[cwg_pkg::SHIFT_W-1], i_shift_x};
    assign w_r5       = $signed({2'b00, w_r});
    assign w_pos_ok   = ({1'b0, i_row} < w_h) && ({1'b0, i_col} < w_w);
    assign w_chan_ok  = {1'b0, i_chan} < w_ch;
    assign w_shift_ok = (w_ch != '0) && (w_dy5 <= w_r5) && (w_dy5 >= -w_r5)
                        && (w_dx5 <= w_r5) && (w_dx5 >= -w_r5);

    // Window slot of the request
    logic [3:0]                  w_dyr;
    logic [3:0]                  w_dxr;
    logic [3:0]                  w_axis;
    logic [cwg_pkg::SLOT_W-1:0]  w_prod;
    logic [cwg_pkg::SLOT_W-1:0]  w_slot;

    assign w_dyr  = 4'(w_dy5 + w_r5);
    assign w_dxr  = 4'(w_dx5 + w_r5);
    assign w_axis = {w_r, 1'b1};
    assign w_prod = {4'b0000, w_dyr} * {4'b0000, w_axis};
    assign w_slot = w_prod + {4'b0000, w_dxr};

    // Captured request and wrap registers
    logic signed [cwg_pkg::WRAP_W-1:0] r_sy;
    logic signed [cwg_pkg::WRAP_W-1:0] r_sx;
    logic signed [cwg_pkg::WRAP_W-1:0] n_sy;
    logic signed [cwg_pkg::WRAP_W-1:0] n_sx;
    logic signed [cwg_pkg::WRAP_W-1:0] w_h9;
    logic signed [cwg_pkg::WRAP_W-1:0] w_w9;
    logic [cwg_pkg::SLOT_W-1:0]        r_slot;
    logic [cwg_pkg::DEPTH_W-1:0]       r_base;
    logic [cwg_pkg::DEPTH_W:0]         w_base_full;
    logic                              w_y_in;
    logic                              w_x_in;

    assign w_h9        = $signed({2'b00, w_h});
    assign w_w9        = $signed({2'b00, w_w});
    assign w_y_in      = !r_sy[cwg_pkg::WRAP_W-1] && (r_sy < w_h9);
    assign w_x_in      = !r_sx[cwg_pkg::WRAP_W-1] && (r_sx < w_w9);
    assign w_base_full = {3'b000, r_slot} * {8'd0, w_ch};

    // One add or subtract of the image size per axis and step
    always_comb begin
        n_sy = r_sy;
        n_sx = r_sx;
        if (r_sy[cwg_pkg::WRAP_W-1]) begin
            n_sy = r_sy + w_h9;
        end else if (r_sy >= w_h9) begin
            n_sy = r_sy - w_h9;
        end
        if (r_sx[cwg_pkg::WRAP_W-1]) begin
            n_sx = r_sx + w_w9;
        end else if (r_sx >= w_w9) begin
            n_sx = r_sx - w_w9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sy   <= $signed({3'b000, i_row}) - $signed({{5{i_shift_y[3]}}, i_shift_y});
            r_sx   <= $signed({3'b000, i_col}) - $signed({{5{i_shift_x[3]}}, i_shift_x});
            r_slot <= w_slot;
        end else if (i_cmd.wrap) begin
            r_sy   <= n_sy;
            r_sx   <= n_sx;
            r_base <= w_base_full[cwg_pkg::DEPTH_W-1:0];
        end
    end

    // Channel counter
    logic [cwg_pkg::CH_W-1:0] r_cnt;
    logic [cwg_pkg::CH_W-1:0] w_rd_chan;
    logic                     w_last;

    assign w_last    = (r_cnt + 3'd1) == w_ch;
    assign w_rd_chan = i_cmd.rd_start ? '0 : r_cnt + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.rd_start) begin
            r_cnt <= '0;
        end else if (i_cmd.emit && !w_last) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // Image store: one write or one read a cycle, registered read data
    logic [cwg_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [cwg_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]            w_wr_addr;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic                         w_rd_en;

    assign w_wr_addr = ADDR_W'((int'(i_chan) * MAX_HEIGHT + int'(i_row)) * MAX_WIDTH
                               + int'(i_col));
    assign w_rd_addr = ADDR_W'((int'(w_rd_chan) * MAX_HEIGHT + int'(r_sy)) * MAX_WIDTH
                               + int'(r_sx));
    assign w_rd_en   = i_cmd.rd_start || (i_cmd.emit && !w_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_wr_addr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Output register
    logic                         r_out_valid;
    logic [cwg_pkg::SAMPLE_W-1:0] r_out_data;
    logic [cwg_pkg::CHAN_W-1:0]   r_out_chan;
    logic [cwg_pkg::DEPTH_W-1:0]  r_out_depth;
    logic                         r_out_last;
    logic                         r_out_err;
    logic                         w_out_free;

    assign w_out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data  <= r_rd_data;
            r_out_chan  <= r_cnt[cwg_pkg::CHAN_W-1:0];
            r_out_depth <= r_base + {7'd0, r_cnt};
            r_out_last  <= w_last;
            r_out_err   <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out_data  <= '0;
            r_out_chan  <= '0;
            r_out_depth <= '0;
            r_out_last  <= 1'b1;
            r_out_err   <= 1'b1;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_data        = r_out_data;
    assign o_out_chan    = r_out_chan;
    assign o_depth_index = r_out_depth;
    assign o_last        = r_out_last;
    assign o_error       = r_out_err;

    // Status to controller
    assign o_status.gather    = (i_op == cwg_pkg::OP_GATHER);
    assign o_status.in_ok     = w_pos_ok && ((i_op == cwg_pkg::OP_GATHER) ? w_shift_ok : w_chan_ok);
    assign o_status.wrap_done = w_y_in && w_x_in;
    assign o_status.out_free  = w_out_free;
    assign o_status.last      = w_last;

    `CWG_ASSERT_IMP(a_read_after_wrap, i_clk, i_rst_n, i_cmd.rd_start, w_y_in && w_x_in, "image read before row and column wrapped")
    `CWG_ASSERT_IMP(a_cnt_in_range, i_clk, i_rst_n, i_cmd.emit, r_cnt < w_ch, "channel count beyond channels in use")
    `CWG_ASSERT_NXT(a_cnt_steps, i_clk, i_rst_n, i_cmd.emit && !w_last, r_cnt == $past(r_cnt) + 3'd1, "channel count did not advance")

endmodule

>>> hdl/circular_window_gather.sv
// Top level of the circular window gather block.
`timescale 1ns / 1ps

// Holds a multi-channel image of 32-bit samples and gathers window samples with
// toroidal wrap. A load request (tuser 0) stores one sample; a bad load or gather
// gives a single error result. A gather first runs the wrap unit, which adds or
// subtracts the image size once per axis and step until the row and column lie
// inside the image; steps are needed whenever the offset carries the row or column
// past an image edge. It then reads the channels in use from the single-port image
// store, one channel per cycle while the output is not stalled. One request is
// worked on at a time; the output register lets the next request be accepted
// while the final result still waits.
module circular_window_gather #(
    parameter int MAX_CHANNELS = cwg_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_HEIGHT   = cwg_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = cwg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS   = cwg_pkg::DEF_MAX_RADIUS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cwg_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cwg_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // chan, row, col, shift_y, shift_x, sample, zero pad
    input  logic [cwg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // op
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // data, out_chan, depth_index, zero pad
    output logic [cwg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // error
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    cwg_pkg::t_cmd    w_cmd;
    cwg_pkg::t_status w_status;

    logic [cwg_pkg::SAMPLE_W-1:0] w_data;
    logic [cwg_pkg::CHAN_W-1:0]   w_out_chan;
    logic [cwg_pkg::DEPTH_W-1:0]  w_depth;

    // Request field unpacking
    logic [cwg_pkg::CHAN_W-1:0]         w_chan;
    logic [cwg_pkg::POS_W-1:0]          w_row;
    logic [cwg_pkg::POS_W-1:0]          w_col;
    logic signed [cwg_pkg::SHIFT_W-1:0] w_shift_y;
    logic signed [cwg_pkg::SHIFT_W-1:0] w_shift_x;
    logic [cwg_pkg::SAMPLE_W-1:0]       w_sample;

    assign w_chan    = s_axis_tdata[cwg_pkg::IN_CHAN_LO +: cwg_pkg::CHAN_W];
    assign w_row     = s_axis_tdata[cwg_pkg::IN_ROW_LO +: cwg_pkg::POS_W];
    assign w_col     = s_axis_tdata[cwg_pkg::IN_COL_LO +: cwg_pkg::POS_W];
    assign w_shift_y = $signed(s_axis_tdata[cwg_pkg::IN_SY_LO +: cwg_pkg::SHIFT_W]);
    assign w_shift_x = $signed(s_axis_tdata[cwg_pkg::IN_SX_LO +: cwg_pkg::SHIFT_W]);
    assign w_sample  = s_axis_tdata[cwg_pkg::IN_SMP_LO +: cwg_pkg::SAMPLE_W];

    cwg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cwg_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_RADIUS   (MAX_RADIUS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_chan        (w_chan),
        .i_row         (w_row),
        .i_col         (w_col),
        .i_shift_y     (w_shift_y),
        .i_shift_x     (w_shift_x),
        .i_sample      (w_sample),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_data        (w_data),
        .o_out_chan    (w_out_chan),
        .o_depth_index (w_depth),
        .o_last        (m_axis_tlast),
        .o_error       (m_axis_tuser)
    );

    // Result packing
    assign m_axis_tdata[cwg_pkg::OUT_CHAN_LO-1:0]                          = w_data;
    assign m_axis_tdata[cwg_pkg::OUT_CHAN_LO +: cwg_pkg::CHAN_W]           = w_out_chan;
    assign m_axis_tdata[cwg_pkg::OUT_DEP_LO +: cwg_pkg::DEPTH_W]           = w_depth;
    assign m_axis_tdata[cwg_pkg::OUT_TDATA_W-1:cwg_pkg::OUT_PAD_LO]        = '0;

endmodule
